// ----- rtl/core/lpr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants of the linear parameter ramp core
// Request and response payloads, divider chain records and lane numbering.
// ----------------------------------------------------------------------------
package lpr_pkg;

	// field widths
	localparam int TW = 32;          // time ticks
	localparam int VW = 16;          // volume, pan and pitch
	localparam int PW = TW + VW;     // elapsed times value difference
	localparam int QW = 18;          // quotient bits kept by the divider
	localparam int NLANE = 3;        // volume, pan, pitch
	localparam int DIV_STEPS = QW;   // one divider cell per quotient bit
	localparam int SW = VW + 4;      // signed width of the final sum

	// lane numbering
	localparam int LANE_VOL = 0;
	localparam int LANE_PAN = 1;
	localparam int LANE_PITCH = 2;

	localparam logic [VW-1:0] MIN_DUR_RESET = 16'd10;

	// where the values are written
	typedef enum logic [1:0] {
		TGT_DUCK = 2'd0,
		TGT_MASTER = 2'd1,
		TGT_WAVE = 2'd2,
		TGT_SOUND = 2'd3
	} target_t;

	// one ramp evaluation request
	typedef struct packed {
		logic [TW-1:0] now_time;
		logic [TW-1:0] from_time;
		logic [TW-1:0] to_time;
		logic [VW-1:0] from_volume;
		logic [VW-1:0] to_volume;
		logic signed [VW-1:0] from_pan;
		logic signed [VW-1:0] to_pan;
		logic [VW-1:0] from_pitch;
		logic [VW-1:0] to_pitch;
		logic [1:0] ramp_flags;
		logic has_wave;
	} req_t;

	// one ramp evaluation response
	typedef struct packed {
		logic [VW-1:0] cur_volume;
		logic signed [VW-1:0] cur_pan;
		logic [VW-1:0] cur_pitch;
		logic [1:0] target_select;
		logic finished;
	} rsp_t;

	// data carried alongside the division
	typedef struct packed {
		logic use_end;
		logic finished;
		target_t target;
		logic el_neg;
		logic [NLANE-1:0] neg;
		logic [NLANE-1:0] ovf;
		logic [NLANE-1:0][VW-1:0] start_val;
		logic [NLANE-1:0][VW-1:0] end_val;
	} side_t;

	// partial remainder and shifting dividend/quotient per lane
	typedef struct packed {
		logic [NLANE-1:0][TW-1:0] rem;
		logic [NLANE-1:0][QW-1:0] pq;
		logic [TW-1:0] divisor;
		side_t side;
	} div_t;

endpackage

// ----- rtl/core/lpr_div_cell.sv -----
// ----------------------------------------------------------------------------
// lpr_div_cell: one restoring division step for all lanes
// Shifts one dividend bit into each remainder, subtracts the duration when
// it fits and shifts the quotient bit in; hands the record to the next cell.
// ----------------------------------------------------------------------------
module lpr_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  lpr_pkg::div_t   in_div,
	output logic            out_vld,
	output lpr_pkg::div_t   out_div
);

	lpr_pkg::div_t nxt;
	logic [lpr_pkg::NLANE-1:0][lpr_pkg::TW:0] shifted;
	logic [lpr_pkg::NLANE-1:0][lpr_pkg::TW:0] trial;
	logic [lpr_pkg::NLANE-1:0] qbit;
	logic vld_s1;
	lpr_pkg::div_t div_s1;

	// trial subtract per lane, keep the difference when no borrow
	always_comb begin
		nxt = in_div;
		for (int l = 0; l < lpr_pkg::NLANE; l++) begin
			shifted[l] = {in_div.rem[l], in_div.pq[l][lpr_pkg::QW-1]};
			trial[l] = shifted[l] - {1'b0, in_div.divisor};
			qbit[l] = ~trial[l][lpr_pkg::TW];
			nxt.rem[l] = qbit[l] ? trial[l][lpr_pkg::TW-1:0] : shifted[l][lpr_pkg::TW-1:0];
			nxt.pq[l] = {in_div.pq[l][lpr_pkg::QW-2:0], qbit[l]};
		end
	end

	// advance the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s1 <= nxt;
		end
	end

	assign out_vld = vld_s1;
	assign out_div = div_s1;

endmodule

// ----- rtl/core/lpr_front.sv -----
// ----------------------------------------------------------------------------
// lpr_front: decode, multiply and divider load stages
// Flags finished and short ramps, picks the target, forms elapsed magnitude and
// value deltas, multiplies and loads the divider chain with an overflow check.
// ----------------------------------------------------------------------------
module lpr_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      req_vld,
	input  lpr_pkg::req_t             req,
	input  logic [lpr_pkg::VW-1:0]    min_dur,
	output logic                      out_vld,
	output lpr_pkg::div_t             out_div
);

	// stage 1 inputs
	logic fin;
	logic short_ramp;
	logic [lpr_pkg::TW:0] short_lim;
	logic el_neg;
	logic [lpr_pkg::TW-1:0] el_mag;
	lpr_pkg::target_t target;
	logic [lpr_pkg::NLANE-1:0][lpr_pkg::VW-1:0] start_v;
	logic [lpr_pkg::NLANE-1:0][lpr_pkg::VW-1:0] end_v;
	logic [lpr_pkg::NLANE-1:0][lpr_pkg::VW:0] diff;
	logic [lpr_pkg::NLANE-1:0][lpr_pkg::VW:0] diff_abs;

	// stage 1 registers
	logic vld_s1;
	lpr_pkg::side_t side_s1;
	logic [lpr_pkg::TW-1:0] el_mag_s1;
	logic [lpr_pkg::TW-1:0] dur_s1;
	logic [lpr_pkg::NLANE-1:0][lpr_pkg::VW-1:0] dmag_s1;

	// stage 2 registers
	logic vld_s2;
	lpr_pkg::side_t side_s2;
	logic [lpr_pkg::TW-1:0] dur_s2;
	logic [lpr_pkg::NLANE-1:0][lpr_pkg::PW-1:0] prod_s2;

	// stage 3
	lpr_pkg::div_t load;
	logic vld_s3;
	lpr_pkg::div_t div_s3;

	// decode the request
	always_comb begin
		fin = req.now_time >= req.to_time;
		short_lim = {1'b0, req.from_time} + {{(lpr_pkg::TW + 1 - lpr_pkg::VW){1'b0}}, min_dur};
		short_ramp = {1'b0, req.to_time} <= short_lim;
		el_neg = req.now_time < req.from_time;
		el_mag = el_neg ? (req.from_time - req.now_time) : (req.now_time - req.from_time);

		priority if (req.ramp_flags[0]) begin
			target = lpr_pkg::TGT_DUCK;
		end else if (req.ramp_flags[1]) begin
			target = lpr_pkg::TGT_MASTER;
		end else if (req.has_wave) begin
			target = lpr_pkg::TGT_WAVE;
		end else begin
			target = lpr_pkg::TGT_SOUND;
		end

		start_v[lpr_pkg::LANE_VOL] = req.from_volume;
		end_v[lpr_pkg::LANE_VOL] = req.to_volume;
		start_v[lpr_pkg::LANE_PAN] = req.from_pan;
		end_v[lpr_pkg::LANE_PAN] = req.to_pan;
		start_v[lpr_pkg::LANE_PITCH] = req.from_pitch;
		end_v[lpr_pkg::LANE_PITCH] = req.to_pitch;

		diff[lpr_pkg::LANE_VOL] = {1'b0, req.to_volume} - {1'b0, req.from_volume};
		diff[lpr_pkg::LANE_PAN] = {req.to_pan[lpr_pkg::VW-1], req.to_pan}
			- {req.from_pan[lpr_pkg::VW-1], req.from_pan};
		diff[lpr_pkg::LANE_PITCH] = {1'b0, req.to_pitch} - {1'b0, req.from_pitch};

		for (int l = 0; l < lpr_pkg::NLANE; l++) begin
			diff_abs[l] = diff[l][lpr_pkg::VW] ? ((lpr_pkg::VW + 1)'(0) - diff[l]) : diff[l];
		end
	end

	// stage 1: hold decoded request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.use_end <= fin | short_ramp;
			side_s1.finished <= fin;
			side_s1.target <= target;
			side_s1.el_neg <= el_neg;
			side_s1.ovf <= '0;
			side_s1.start_val <= start_v;
			side_s1.end_val <= end_v;
			el_mag_s1 <= el_mag;
			dur_s1 <= req.to_time - req.from_time;
			for (int l = 0; l < lpr_pkg::NLANE; l++) begin
				side_s1.neg[l] <= el_neg ^ diff[l][lpr_pkg::VW];
				dmag_s1[l] <= diff_abs[l][lpr_pkg::VW-1:0];
			end
		end
	end

	// stage 2: multiply elapsed magnitude by each delta magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			for (int l = 0; l < lpr_pkg::NLANE; l++) begin
				prod_s2[l] <= {{lpr_pkg::VW{1'b0}}, el_mag_s1}
					* {{lpr_pkg::TW{1'b0}}, dmag_s1[l]};
			end
			dur_s2 <= dur_s1;
		end
	end

	// stage 3: flag quotients that exceed the kept bits, load remainders
	always_comb begin
		load.divisor = dur_s2;
		load.side = side_s2;
		for (int l = 0; l < lpr_pkg::NLANE; l++) begin
			load.rem[l] = {{(lpr_pkg::TW + lpr_pkg::QW - lpr_pkg::PW){1'b0}},
				prod_s2[l][lpr_pkg::PW-1:lpr_pkg::QW]};
			load.pq[l] = prod_s2[l][lpr_pkg::QW-1:0];
			load.side.ovf[l] = load.rem[l] >= dur_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s3 <= load;
		end
	end

	assign out_vld = vld_s3;
	assign out_div = div_s3;

endmodule

// ----- rtl/core/linear_parameter_ramp_core.sv -----
// ----------------------------------------------------------------------------
// linear_parameter_ramp_core: evaluates one volume/pan/pitch ramp per request
//
// A request carries the current time and one ramp record. The response gives
// the three interpolated values (start plus elapsed * delta / duration,
// truncated toward zero and saturated), the target and the finished flag.
// Ramps that are finished or no longer than min_duration give end values.
// Both channels move one request per cycle with valid and stall; the
// receiver stalls by raising rsp_stall.
// An accepted request passes three front stages (decode, multiply, divider
// load), 18 divider cells that each produce one quotient bit, and the
// output register. Throughput is one request per cycle; while a response
// waits under stall the whole pipeline holds and req_stall is raised.
// Reset empties the pipeline and sets min_duration to 10 ticks; cfg_we
// writes min_duration from cfg_wdata. The user must write it only while no
// request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module linear_parameter_ramp_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  lpr_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output lpr_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [lpr_pkg::VW-1:0]    cfg_wdata
);

	logic en;
	logic [lpr_pkg::VW-1:0] min_dur_q;
	logic [lpr_pkg::DIV_STEPS:0] chain_vld;
	lpr_pkg::div_t chain_div [lpr_pkg::DIV_STEPS+1];
	lpr_pkg::div_t last;
	logic signed [lpr_pkg::SW-1:0] base [lpr_pkg::NLANE];
	logic signed [lpr_pkg::SW-1:0] sum [lpr_pkg::NLANE];
	logic signed [lpr_pkg::SW-1:0] lo [lpr_pkg::NLANE];
	logic signed [lpr_pkg::SW-1:0] hi [lpr_pkg::NLANE];
	logic [lpr_pkg::NLANE-1:0][lpr_pkg::VW-1:0] val;
	lpr_pkg::rsp_t rsp_d;
	logic rsp_valid_q;
	lpr_pkg::rsp_t rsp_q;

	// advance the pipeline unless a response is held
	assign en = ~(rsp_valid_q & rsp_stall);
	assign req_stall = ~en;

	// hold the minimum duration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dur_q <= lpr_pkg::MIN_DUR_RESET;
		end else if (cfg_we) begin
			min_dur_q <= cfg_wdata;
		end
	end

	lpr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.req_vld (req_valid),
		.req     (req),
		.min_dur (min_dur_q),
		.out_vld (chain_vld[0]),
		.out_div (chain_div[0])
	);

	// divider cell chain, one quotient bit per cell
	for (genvar g = 0; g < lpr_pkg::DIV_STEPS; g++) begin : g_cell
		lpr_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_vld  (chain_vld[g]),
			.in_div  (chain_div[g]),
			.out_vld (chain_vld[g+1]),
			.out_div (chain_div[g+1])
		);
	end

	assign last = chain_div[lpr_pkg::DIV_STEPS];

	// apply sign, add start value, saturate, pick end values for finished and short ramps
	always_comb begin
		for (int l = 0; l < lpr_pkg::NLANE; l++) begin
			if (l == lpr_pkg::LANE_PAN) begin
				base[l] = {{(lpr_pkg::SW - lpr_pkg::VW){last.side.start_val[l][lpr_pkg::VW-1]}},
					last.side.start_val[l]};
				lo[l] = -(lpr_pkg::SW'(32768));
				hi[l] = lpr_pkg::SW'(32767);
			end else begin
				base[l] = {{(lpr_pkg::SW - lpr_pkg::VW){1'b0}}, last.side.start_val[l]};
				lo[l] = '0;
				hi[l] = lpr_pkg::SW'(65535);
			end
			if (last.side.neg[l]) begin
				sum[l] = base[l] - {{(lpr_pkg::SW - lpr_pkg::QW){1'b0}}, last.pq[l]};
			end else begin
				sum[l] = base[l] + {{(lpr_pkg::SW - lpr_pkg::QW){1'b0}}, last.pq[l]};
			end
			priority if (last.side.use_end) begin
				val[l] = last.side.end_val[l];
			end else if (last.side.ovf[l]) begin
				val[l] = last.side.neg[l] ? lo[l][lpr_pkg::VW-1:0] : hi[l][lpr_pkg::VW-1:0];
			end else if (sum[l] < lo[l]) begin
				val[l] = lo[l][lpr_pkg::VW-1:0];
			end else if (sum[l] > hi[l]) begin
				val[l] = hi[l][lpr_pkg::VW-1:0];
			end else begin
				val[l] = sum[l][lpr_pkg::VW-1:0];
			end
		end
		rsp_d.cur_volume = val[lpr_pkg::LANE_VOL];
		rsp_d.cur_pan = val[lpr_pkg::LANE_PAN];
		rsp_d.cur_pitch = val[lpr_pkg::LANE_PITCH];
		rsp_d.target_select = last.side.target;
		rsp_d.finished = last.side.finished;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= chain_vld[lpr_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef SYNTH
	// a held response freezes every stage of the pipeline
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> ($stable(chain_vld) && $stable(rsp)))
		else $error("pipeline moved while response was stalled");

	// quotient overflow only comes from extrapolating before the start
	a_ovf_backward: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_vld[lpr_pkg::DIV_STEPS] && !last.side.use_end && !last.side.el_neg)
		|-> (last.side.ovf == '0))
		else $error("quotient overflow on forward interpolation");

	// forward interpolation keeps the quotient below the value range
	a_fwd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_vld[lpr_pkg::DIV_STEPS] && !last.side.use_end && !last.side.el_neg)
		|-> (last.pq[lpr_pkg::LANE_VOL][lpr_pkg::QW-1:lpr_pkg::VW] == '0
			&& last.pq[lpr_pkg::LANE_PAN][lpr_pkg::QW-1:lpr_pkg::VW] == '0
			&& last.pq[lpr_pkg::LANE_PITCH][lpr_pkg::QW-1:lpr_pkg::VW] == '0))
		else $error("forward quotient exceeds value range");
`endif

endmodule
